@@ design/fjps_pkg.sv @@
// shared types and constants for the flat json pair splitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fjps_pkg;

    localparam int PAIR_LIMIT     = 10;
    localparam int KEY_STORE      = 32;
    localparam int VALUE_STORE    = 64;
    localparam int MESSAGE_WINDOW = 256;
    localparam int KEY_AW         = $clog2(KEY_STORE);
    localparam int VAL_AW         = $clog2(VALUE_STORE);
    localparam int POS_W          = $clog2(MESSAGE_WINDOW);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] PART_KEY  = 2'd0;
    localparam logic [1:0] PART_VAL  = 2'd1;
    localparam logic [1:0] PART_DONE = 2'd2;

    typedef enum logic [1:0] {
        PH_KEY_SKIP = 2'd0,
        PH_KEY_BODY = 2'd1,
        PH_VAL_SKIP = 2'd2,
        PH_VAL_BODY = 2'd3
    } t_phase;

    typedef struct packed {
        logic load;
        logic feed;
        logic setup;
        logic sel_val;
        logic cap;
        logic adv;
        logic clr;
        logic pair_inc;
        logic msg_reset;
        logic show_done;
    } t_cmd;

    typedef struct packed {
        logic do_finish;
        logic emit_ok;
        logic k_zero;
        logic j_last;
        logic part_end;
        logic sel;
        logic lastb;
    } t_sts;

    typedef struct packed {
        logic [3:0] pair_index;
        logic [1:0] part;
        logic [7:0] char_a;
        logic [7:0] char_b;
        logic [7:0] char_c;
        logic [7:0] char_d;
        logic [2:0] char_count;
        logic       end_of_part;
        logic [3:0] pairs_found;
        logic       last;
    } t_res;

endpackage
`default_nettype wire

@@ design/fjps_if.sv @@
// stream interfaces for input bytes and result chunks
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface fjps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fjps_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pair_index;
    logic [1:0] part;
    logic [7:0] char_a;
    logic [7:0] char_b;
    logic [7:0] char_c;
    logic [7:0] char_d;
    logic [2:0] char_count;
    logic       end_of_part;
    logic [3:0] pairs_found;
    logic       last;
    modport source (output valid, output pair_index, output part, output char_a,
                    output char_b, output char_c, output char_d, output char_count,
                    output end_of_part, output pairs_found, output last, input ready);
    modport sink (input valid, input pair_index, input part, input char_a,
                  input char_b, input char_c, input char_d, input char_count,
                  input end_of_part, input pairs_found, input last, output ready);
endinterface
`default_nettype wire

@@ design/fjps_ctrl.sv @@
// sequencer for byte intake, chunk reads and result transfers
// depends on fjps_pkg
`timescale 1ns / 1ps
`default_nettype none
module fjps_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    input  fjps_pkg::t_sts i_sts,
    output fjps_pkg::t_cmd o_cmd
);
    import fjps_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FEED = 7'b0000010,
        S_FIN  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_CAP  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FEED;
                end
            end
            S_FEED: begin
                o_cmd.feed = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_sts.do_finish && i_sts.emit_ok) begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_RD;
                end else begin
                    o_cmd.clr = i_sts.do_finish;
                    n_state   = i_sts.lastb ? S_DONE : S_IDLE;
                end
            end
            S_RD: begin
                n_state = i_sts.k_zero ? S_OUT : S_CAP;
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = i_sts.j_last ? S_OUT : S_RD;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (!i_sts.part_end) begin
                        o_cmd.adv = 1'b1;
                        n_state   = S_RD;
                    end else if (!i_sts.sel) begin
                        o_cmd.setup   = 1'b1;
                        o_cmd.sel_val = 1'b1;
                        n_state       = S_RD;
                    end else begin
                        o_cmd.pair_inc = 1'b1;
                        o_cmd.clr      = 1'b1;
                        n_state        = i_sts.lastb ? S_DONE : S_IDLE;
                    end
                end
            end
            S_DONE: begin
                o_out_valid     = 1'b1;
                o_cmd.show_done = 1'b1;
                if (i_out_ready) begin
                    o_cmd.msg_reset = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ design/fjps_dp.sv @@
// token stores, lengths, phase and chunk assembly
// depends on fjps_pkg
`timescale 1ns / 1ps
`default_nettype none
module fjps_dp (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire [7:0]      i_data_byte,
    input  wire            i_last_byte,
    input  fjps_pkg::t_cmd i_cmd,
    output fjps_pkg::t_sts o_sts,
    output fjps_pkg::t_res o_res
);
    import fjps_pkg::*;

    logic [7:0] r_key_mem [KEY_STORE];
    logic [7:0] r_val_mem [VALUE_STORE];
    logic [7:0] r_kq;
    logic [7:0] r_vq;

    logic [7:0]       r_byte;
    logic             r_lastb;
    logic [POS_W-1:0] r_pos;
    t_phase           r_phase;
    logic [7:0]       r_klen;
    logic [7:0]       r_vlen;
    logic [7:0]       r_kfirst;
    logic [7:0]       r_kfin;
    logic [7:0]       r_vfirst;
    logic [7:0]       r_vfin;
    logic [3:0]       r_pairs;
    logic             r_dofin;
    logic             r_sel;
    logic             r_start;
    logic [7:0]       r_n;
    logic [7:0]       r_cpos;
    logic [1:0]       r_j;
    logic [7:0]       r_chunk [4];

    logic       in_win;
    logic       msg_end;
    logic       drop;
    logic       take;
    logic       put_key;
    logic       put_val;
    logic [7:0] s_len;
    logic [7:0] s_first;
    logic [7:0] s_fin;
    logic       s_strip;
    logic [7:0] s_n;
    logic [7:0] s_cap;
    logic [7:0] rem;
    logic [2:0] k;
    logic [7:0] rd_addr;

    assign in_win  = r_pos != POS_W'(MESSAGE_WINDOW - 1);
    assign msg_end = r_lastb || (r_pos == POS_W'(MESSAGE_WINDOW - 2));
    assign drop    = (r_pos == '0 && r_byte == CH_LBRACE) || (msg_end && r_byte == CH_RBRACE);
    assign take    = i_cmd.feed && in_win && !drop && (r_byte != CH_COMMA);

    always_comb begin
        put_key = 1'b0;
        put_val = 1'b0;
        case (r_phase)
            PH_KEY_SKIP: put_key = (r_byte != CH_SPACE) && (r_byte != CH_COLON);
            PH_KEY_BODY: put_key = r_byte != CH_COLON;
            PH_VAL_SKIP: put_val = r_byte != CH_SPACE;
            PH_VAL_BODY: put_val = 1'b1;
            default: put_key = 1'b0;
        endcase
        put_key = put_key && take;
        put_val = put_val && take;
    end

    // string bounds for the part being set up
    always_comb begin
        s_len   = i_cmd.sel_val ? r_vlen : r_klen;
        s_first = i_cmd.sel_val ? r_vfirst : r_kfirst;
        s_fin   = i_cmd.sel_val ? r_vfin : r_kfin;
        s_cap   = i_cmd.sel_val ? 8'(VALUE_STORE - 1) : 8'(KEY_STORE - 1);
        s_strip = (s_len >= 8'd2) && (s_first == CH_QUOTE) && (s_fin == CH_QUOTE);
        s_n     = s_strip ? s_len - 8'd2 : s_len;
        if (s_n > s_cap) begin
            s_n = s_cap;
        end
    end

    assign rem     = r_n - r_cpos;
    assign k       = (rem > 8'd4) ? 3'd4 : rem[2:0];
    assign rd_addr = 8'(r_start) + r_cpos + 8'(r_j);

    always_ff @(posedge i_clk) begin
        if (put_key && r_klen < 8'(KEY_STORE)) begin
            r_key_mem[r_klen[KEY_AW-1:0]] <= r_byte;
        end
        if (put_val && r_vlen < 8'(VALUE_STORE)) begin
            r_val_mem[r_vlen[VAL_AW-1:0]] <= r_byte;
        end
        r_kq <= r_key_mem[rd_addr[KEY_AW-1:0]];
        r_vq <= r_val_mem[rd_addr[VAL_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte  <= i_data_byte;
            r_lastb <= i_last_byte;
        end
        if (i_cmd.setup) begin
            r_start <= s_strip;
            r_n     <= s_n;
        end
        if (i_cmd.setup || i_cmd.adv) begin
            r_cpos <= i_cmd.setup ? 8'd0 : r_cpos + 8'(k);
            r_j    <= 2'd0;
            for (int i = 0; i < 4; i++) begin
                r_chunk[i] <= 8'd0;
            end
        end else if (i_cmd.cap) begin
            r_chunk[r_j] <= r_sel ? r_vq : r_kq;
            r_j          <= r_j + 2'd1;
        end
        if (put_key) begin
            if (r_klen == 8'd0) begin
                r_kfirst <= r_byte;
            end
        end
        if (put_val) begin
            if (r_vlen == 8'd0) begin
                r_vfirst <= r_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_KEY_SKIP;
            r_klen  <= 8'd0;
            r_vlen  <= 8'd0;
            r_kfin  <= 8'd0;
            r_vfin  <= 8'd0;
            r_pairs <= 4'd0;
            r_dofin <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (i_cmd.feed) begin
                r_dofin <= in_win && (msg_end || (!drop && r_byte == CH_COMMA));
                if (in_win) begin
                    r_pos <= r_pos + POS_W'(1);
                end
                if (take) begin
                    case (r_phase)
                        PH_KEY_SKIP: begin
                            if (r_byte == CH_COLON) begin
                                r_phase <= PH_VAL_SKIP;
                            end else if (r_byte != CH_SPACE) begin
                                r_phase <= PH_KEY_BODY;
                            end
                        end
                        PH_KEY_BODY: begin
                            if (r_byte == CH_COLON) begin
                                r_phase <= PH_VAL_SKIP;
                            end
                        end
                        PH_VAL_SKIP: begin
                            if (r_byte != CH_SPACE) begin
                                r_phase <= PH_VAL_BODY;
                            end
                        end
                        default: r_phase <= r_phase;
                    endcase
                end
                if (put_key) begin
                    r_kfin <= r_byte;
                    if (r_klen != 8'd255) begin
                        r_klen <= r_klen + 8'd1;
                    end
                end
                if (put_val) begin
                    r_vfin <= r_byte;
                    if (r_vlen != 8'd255) begin
                        r_vlen <= r_vlen + 8'd1;
                    end
                end
            end
            if (i_cmd.setup) begin
                r_sel <= i_cmd.sel_val;
            end
            if (i_cmd.pair_inc) begin
                r_pairs <= r_pairs + 4'd1;
            end
            if (i_cmd.clr || i_cmd.msg_reset) begin
                r_phase <= PH_KEY_SKIP;
                r_klen  <= 8'd0;
                r_vlen  <= 8'd0;
                r_kfin  <= 8'd0;
                r_vfin  <= 8'd0;
            end
            if (i_cmd.msg_reset) begin
                r_pos   <= '0;
                r_pairs <= 4'd0;
            end
        end
    end

    always_comb begin
        o_sts.do_finish = r_dofin;
        o_sts.emit_ok   = (r_phase == PH_VAL_SKIP || r_phase == PH_VAL_BODY)
                          && (r_pairs < 4'(PAIR_LIMIT));
        o_sts.k_zero    = k == 3'd0;
        o_sts.j_last    = 3'(r_j) == k - 3'd1;
        o_sts.part_end  = (r_cpos + 8'(k)) >= r_n;
        o_sts.sel       = r_sel;
        o_sts.lastb     = r_lastb;
    end

    always_comb begin
        if (i_cmd.show_done) begin
            o_res             = '0;
            o_res.part        = PART_DONE;
            o_res.pairs_found = r_pairs;
            o_res.last        = 1'b1;
        end else begin
            o_res.pair_index  = r_pairs;
            o_res.part        = r_sel ? PART_VAL : PART_KEY;
            o_res.char_a      = r_chunk[0];
            o_res.char_b      = r_chunk[1];
            o_res.char_c      = r_chunk[2];
            o_res.char_d      = r_chunk[3];
            o_res.char_count  = k;
            o_res.end_of_part = o_sts.part_end;
            o_res.pairs_found = r_pairs + 4'd1;
            o_res.last        = o_sts.part_end && r_sel && !r_lastb;
        end
    end
endmodule
`default_nettype wire

@@ design/flat_json_pair_splitter.sv @@
// top level of the flat json pair splitter: controller plus datapath
// depends on fjps_pkg, fjps_if, fjps_ctrl, fjps_dp
//
// channel  dir  payload
// i_in     in   data_byte, last_byte
// o_out    out  pair_index, part, char_a..d, char_count, end_of_part, pairs_found, last
//
// a byte with no result passes through accept, apply and finish check (S_IDLE, S_FEED, S_FIN)
// each output chunk reads its characters one by one (read, then capture) before the transfer,
// an empty string chunk goes from read straight to transfer; one registered read port per key/value memory
// the done item is its own transfer after the last chunk; output stalls hold the sequencer in place
// reset is synchronous active low; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module flat_json_pair_splitter (
    input wire        i_clk,
    input wire        i_rst_n,
    fjps_in_if.sink   i_in,
    fjps_out_if.source o_out
);
    import fjps_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_res res;

    fjps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fjps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (res)
    );

    assign o_out.pair_index  = res.pair_index;
    assign o_out.part        = res.part;
    assign o_out.char_a      = res.char_a;
    assign o_out.char_b      = res.char_b;
    assign o_out.char_c      = res.char_c;
    assign o_out.char_d      = res.char_d;
    assign o_out.char_count  = res.char_count;
    assign o_out.end_of_part = res.end_of_part;
    assign o_out.pairs_found = res.pairs_found;
    assign o_out.last        = res.last;
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for the flat json pair splitter: drives byte streams, predicts chunks, compares
// depends on fjps_pkg, fjps_if and the flat_json_pair_splitter rtl
`timescale 1ns / 1ps
module tb_top;
    import fjps_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    fjps_in_if  in_ch ();
    fjps_out_if out_ch ();

    flat_json_pair_splitter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_byte  byte_queue[$];
    t_res   chunk_queue[$];
    int     error_count = 0;
    int     chunks_seen = 0;
    int     bytes_sent = 0;
    int     messages_sent = 0;
    int     send_idle_pct = 15;
    int     recv_idle_pct = 59;
    int     hold_cycles = 0;
    bit     hold_go = 1'b0;
    bit     hold_on = 1'b0;
    longint cycle_count = 0;
    bit     stim_done = 1'b0;

    // splitter state mirror
    logic [7:0] key_mem[KEY_STORE];
    logic [7:0] val_mem[VALUE_STORE];
    int         key_len, val_len;
    logic [7:0] key_fin, val_fin;
    t_phase     phase;
    int         pair_cnt;
    int         msg_pos;

    function automatic void clear_message();
        key_len = 0;
        val_len = 0;
        key_fin = 8'd0;
        val_fin = 8'd0;
        phase = PH_KEY_SKIP;
        pair_cnt = 0;
        msg_pos = 0;
    endfunction

    function automatic void store_char(bit is_val, logic [7:0] c);
        if (is_val) begin
            if (val_len < VALUE_STORE) val_mem[val_len] = c;
            if (val_len < 255) val_len++;
            val_fin = c;
        end else begin
            if (key_len < KEY_STORE) key_mem[key_len] = c;
            if (key_len < 255) key_len++;
            key_fin = c;
        end
    endfunction

    function automatic void queue_chunks(bit is_val);
        int store, len, start, n, pos, k;
        logic [7:0] fin, first;
        logic [7:0] ch[4];
        t_res r;
        store = is_val ? VALUE_STORE : KEY_STORE;
        len = is_val ? val_len : key_len;
        fin = is_val ? val_fin : key_fin;
        first = (len == 0) ? 8'd0 : (is_val ? val_mem[0] : key_mem[0]);
        start = 0;
        n = len;
        pos = 0;
        if (len >= 2 && first == CH_QUOTE && fin == CH_QUOTE) begin
            start = 1;
            n = len - 2;
        end
        if (n > store - 1) n = store - 1;
        forever begin
            k = (n - pos > 4) ? 4 : n - pos;
            for (int j = 0; j < 4; j++) begin
                ch[j] = 8'd0;
                if (j < k && start + pos + j < store)
                    ch[j] = is_val ? val_mem[start + pos + j] : key_mem[start + pos + j];
            end
            r = '0;
            r.pair_index = pair_cnt[3:0];
            r.part = is_val ? PART_VAL : PART_KEY;
            r.char_a = ch[0];
            r.char_b = ch[1];
            r.char_c = ch[2];
            r.char_d = ch[3];
            r.char_count = k[2:0];
            r.end_of_part = (pos + k >= n);
            r.pairs_found = 4'(pair_cnt + 1);
            chunk_queue.insert(chunk_queue.size(), r);
            pos += k;
            if (pos >= n) break;
        end
    endfunction

    function automatic void close_token();
        if (phase inside {PH_VAL_SKIP, PH_VAL_BODY} && pair_cnt < PAIR_LIMIT) begin
            queue_chunks(1'b0);
            queue_chunks(1'b1);
            pair_cnt++;
        end
        phase = PH_KEY_SKIP;
        key_len = 0;
        val_len = 0;
        key_fin = 8'd0;
        val_fin = 8'd0;
    endfunction

    function automatic void apply_char(logic [7:0] c);
        if (c == CH_COMMA) begin
            close_token();
            return;
        end
        case (phase)
            PH_KEY_SKIP: begin
                if (c == CH_COLON) phase = PH_VAL_SKIP;
                else if (c != CH_SPACE) begin
                    phase = PH_KEY_BODY;
                    store_char(1'b0, c);
                end
            end
            PH_KEY_BODY: begin
                if (c == CH_COLON) phase = PH_VAL_SKIP;
                else store_char(1'b0, c);
            end
            PH_VAL_SKIP: begin
                if (c != CH_SPACE) begin
                    phase = PH_VAL_BODY;
                    store_char(1'b1, c);
                end
            end
            default: store_char(1'b1, c);
        endcase
    endfunction

    function automatic void predict_byte(t_byte b);
        int prior_count;
        bit at_end;
        t_res r;
        prior_count = chunk_queue.size();
        if (msg_pos < MESSAGE_WINDOW - 1) begin
            at_end = b.last_byte || msg_pos == MESSAGE_WINDOW - 2;
            if (!((msg_pos == 0 && b.data_byte == CH_LBRACE) ||
                  (at_end && b.data_byte == CH_RBRACE)))
                apply_char(b.data_byte);
            if (at_end) close_token();
            msg_pos++;
        end
        if (b.last_byte) begin
            r = '0;
            r.part = PART_DONE;
            r.pairs_found = 4'(pair_cnt);
            chunk_queue.insert(chunk_queue.size(), r);
            clear_message();
        end
        if (chunk_queue.size() > prior_count) chunk_queue[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on chunk %0d: %s got %0d expected %0d", chunks_seen, what, got, want);
        error_count++;
    endtask

    // stimulus builders
    function automatic void push_text(string s, bit close_msg);
        t_byte b;
        for (int i = 0; i < s.len(); i++) begin
            b.data_byte = s[i];
            b.last_byte = close_msg && (i == s.len() - 1);
            byte_queue.insert(byte_queue.size(), b);
        end
        if (close_msg) messages_sent++;
    endfunction

    function automatic string rand_word(int max_len);
        string s;
        int n;
        byte pool[10] = '{"a", "Z", "0", "9", " ", "\"", ":", "_", "x", "-"};
        s = "";
        n = $urandom_range(max_len, 0);
        for (int i = 0; i < n; i++)
            s = {s, string'(($urandom_range(3, 0) == 0) ? pool[$urandom_range(9, 0)]
                                                         : byte'($urandom_range(126, 33)))};
        return s;
    endfunction

    function automatic void push_random_message();
        string s;
        int pairs;
        s = "";
        if ($urandom_range(9, 0) == 0) begin
            // noise bytes, any nonzero value
            for (int i = $urandom_range(12, 1); i > 0; i--)
                s = {s, string'(byte'($urandom_range(255, 1)))};
            push_text(s, 1'b1);
            return;
        end
        pairs = $urandom_range(4, 1);
        if ($urandom_range(3, 0) != 0) s = "{";
        for (int p = 0; p < pairs; p++) begin
            if (p > 0) s = {s, ($urandom_range(4, 0) == 0) ? ",," : ","};
            if ($urandom_range(2, 0) == 0) s = {s, " "};
            if ($urandom_range(1, 0) == 0) s = {s, "\"", rand_word(8), "\""};
            else s = {s, rand_word(6)};
            if ($urandom_range(7, 0) != 0) s = {s, ":"};
            if ($urandom_range(2, 0) == 0) s = {s, "  "};
            if ($urandom_range(1, 0) == 0) s = {s, "\"", rand_word(10), "\""};
            else s = {s, rand_word(7)};
        end
        if ($urandom_range(3, 0) != 0) s = {s, "}"};
        push_text(s, 1'b1);
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= 8'd0;
            in_ch.last_byte <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_byte('{in_ch.data_byte, in_ch.last_byte});
                bytes_sent <= bytes_sent + 1;
            end
            if ((!in_ch.valid || in_ch.ready) ) begin
                if (byte_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    t_byte b;
                    b = byte_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= b.data_byte;
                    in_ch.last_byte <= b.last_byte;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall, counted here
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_res want;
                chunks_seen <= chunks_seen + 1;
                if (chunk_queue.size() == 0) begin
                    $display("unexpected chunk transfer at cycle %0d", cycle_count);
                    error_count++;
                end else begin
                    want = chunk_queue.pop_front();
                    if (out_ch.pair_index != want.pair_index)
                        report_mismatch("pair_index", out_ch.pair_index, want.pair_index);
                    if (out_ch.part != want.part)
                        report_mismatch("part", out_ch.part, want.part);
                    if (out_ch.char_a != want.char_a)
                        report_mismatch("char_a", out_ch.char_a, want.char_a);
                    if (out_ch.char_b != want.char_b)
                        report_mismatch("char_b", out_ch.char_b, want.char_b);
                    if (out_ch.char_c != want.char_c)
                        report_mismatch("char_c", out_ch.char_c, want.char_c);
                    if (out_ch.char_d != want.char_d)
                        report_mismatch("char_d", out_ch.char_d, want.char_d);
                    if (out_ch.char_count != want.char_count)
                        report_mismatch("char_count", out_ch.char_count, want.char_count);
                    if (out_ch.end_of_part != want.end_of_part)
                        report_mismatch("end_of_part", out_ch.end_of_part, want.end_of_part);
                    if (out_ch.pairs_found != want.pairs_found)
                        report_mismatch("pairs_found", out_ch.pairs_found, want.pairs_found);
                    if (out_ch.last != want.last)
                        report_mismatch("last", out_ch.last, want.last);
                end
            end
            if (hold_on) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("timeout with %0d chunks outstanding", chunk_queue.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        string s;
        clear_message();
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty bodies, quotes, spaces, extremes
        push_text("{", 1'b1);
        push_text("}", 1'b1);
        push_text("{}", 1'b1);
        push_text("{ \"k\" : \"v\",x:,:y,,nocolon}", 1'b1);
        push_text({"{a:", string'(8'hff), string'(8'h80), string'(8'h01), "\"}"}, 1'b1);
        push_text("\"\":\"\"", 1'b1);
        // long key and value truncation, then a token cut off at the window
        s = "{";
        for (int i = 0; i < 33; i++) s = {s, "K"};
        s = {s, ":\""};
        for (int i = 0; i < 65; i++) s = {s, string'(byte'(8'h41 + i % 26))};
        s = {s, "\",k:"};
        for (int i = 0; i < 150; i++) s = {s, "v"};
        push_text({s, "}"}, 1'b1);

        wait (byte_queue.size() == 0);
        // pair limit, block fills while the receiver holds off
        s = "{";
        for (int i = 0; i < 11; i++) s = {s, "a:,"};
        push_text({s, "b:c}"}, 1'b1);
        hold_go = 1'b1;

        for (int ph = 1; ph < 3; ph++) begin
            wait (byte_queue.size() == 0);
            if (ph == 1) begin
                send_idle_pct = 59;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            push_random_message();
        end

        wait (byte_queue.size() == 0 && !in_ch.valid);
        wait (chunk_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        stim_done = 1'b1;
        $display("covered %0d bytes in %0d messages, %0d chunks checked",
                 bytes_sent, messages_sent, chunks_seen);
        if (error_count == 0 && chunk_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
